// ===== rtl/core/ksa_pkg.sv =====
package ksa_pkg;

  localparam int unsigned Entries = 32;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned SumW = 64;
  localparam int unsigned CntW = 32;
  localparam int unsigned DropW = 16;
  localparam logic [CntW-1:0] CountMax = '1;
  localparam logic [DropW-1:0] DropMax = '1;

  localparam logic ReqAdd = 1'b0;
  localparam logic ReqFlush = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic signed [SumW-1:0] sum;
    logic [CntW-1:0] count;
    logic signed [ValW-1:0] min;
    logic signed [ValW-1:0] max;
  } entry_t;

  // Token passed down the cell chain during an add.
  typedef struct packed {
    logic active;
    logic done;
    logic [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } tok_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ksa_cell.sv =====
// One slot. An add token passes through: a matching valid cell absorbs it,
// otherwise the first empty cell it reaches opens. During a flush the slots
// shift toward cell 0 one place per shift pulse.
module ksa_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ksa_pkg::cell_ctrl_t     ctrl_i,
  input  ksa_pkg::tok_t           tok_i,
  output ksa_pkg::tok_t           tok_o,
  input  logic                    nxt_valid_i,
  input  ksa_pkg::entry_t         nxt_entry_i,
  output logic                    valid_o,
  output ksa_pkg::entry_t         entry_o
);

  logic valid_q, valid_d;
  ksa_pkg::entry_t ent_q, ent_d;
  ksa_pkg::tok_t tok_q, tok_d;
  logic hit;

  assign hit = tok_i.active && !tok_i.done && valid_q && (ent_q.key == tok_i.key);

  always_comb begin
    valid_d = valid_q;
    ent_d = ent_q;
    tok_d = tok_i;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      tok_d.active = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = nxt_valid_i;
      ent_d = nxt_entry_i;
    end else if (tok_i.active && !tok_i.done) begin
      if (hit) begin
        if (ent_q.count != ksa_pkg::CountMax) begin
          ent_d.sum = ent_q.sum + ksa_pkg::SumW'(tok_i.value);
          ent_d.count = ent_q.count + 1'b1;
        end
        if (tok_i.value < ent_q.min) ent_d.min = tok_i.value;
        if (tok_i.value > ent_q.max) ent_d.max = tok_i.value;
        tok_d.done = 1'b1;
      end else if (!valid_q) begin
        valid_d = 1'b1;
        ent_d.key = tok_i.key;
        ent_d.sum = ksa_pkg::SumW'(tok_i.value);
        ent_d.count = ksa_pkg::CntW'(1);
        ent_d.min = tok_i.value;
        ent_d.max = tok_i.value;
        tok_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign tok_o = tok_q;
  assign valid_o = valid_q;
  assign entry_o = ent_q;

endmodule

// ===== rtl/core/ksa_div.sv =====
// Signed 64 / unsigned 32 division, one quotient bit per cycle, truncated.
module ksa_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [ksa_pkg::SumW-1:0] num_i,
  input  logic [ksa_pkg::CntW-1:0]        den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic signed [ksa_pkg::ValW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(ksa_pkg::SumW + 1);

  logic [ksa_pkg::SumW-1:0] quo_q, quo_d;
  logic [ksa_pkg::CntW:0] rem_q, rem_d;
  logic [ksa_pkg::CntW-1:0] den_q;
  logic neg_q;
  logic [StepW-1:0] step_q;
  logic busy_q, done_q;
  logic [ksa_pkg::CntW:0] trial;
  logic [ksa_pkg::SumW-1:0] res;

  always_comb begin
    trial = {rem_q[ksa_pkg::CntW-1:0], quo_q[ksa_pkg::SumW-1]};
    quo_d = {quo_q[ksa_pkg::SumW-2:0], 1'b0};
    rem_d = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
    res = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == StepW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(ksa_pkg::SumW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[ksa_pkg::SumW-1] ? (~num_i + 1'b1) : num_i;
      neg_q <= num_i[ksa_pkg::SumW-1];
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = res[ksa_pkg::ValW-1:0];

endmodule

// ===== rtl/core/keyed_stats_accumulator.sv =====
// channel | valid      | stall      | payload
// in      | in_valid_i | in_stall_o | req_type_i, source_id_i, metric_type_i, sample_value_i
// out     | out_valid_o| out_stall_i| out_source_id_o .. last_o
// An add walks the token down the chain of Entries cells.
// A flush runs each valid slot through the bit-serial 64-bit divider, emits its record
// once the output is free and shifts the table, then clears the table and the drop count.
// Reset empties all slots and the drop count; no clearing pass is needed.
// Input stall is high whenever an item is in progress.
module keyed_stats_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] source_id_i,
  input  logic [15:0] metric_type_i,
  input  logic signed [31:0] sample_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_source_id_o,
  output logic [15:0] out_metric_type_o,
  output logic signed [31:0] average_o,
  output logic signed [31:0] minimum_o,
  output logic signed [31:0] maximum_o,
  output logic [15:0] dropped_keys_o,
  output logic        last_o
);

  localparam int unsigned N = ksa_pkg::Entries;
  localparam int unsigned CntW = $clog2(N + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_FSTART, S_FDIV, S_FOUT, S_FSHIFT
  } state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;
  logic [ksa_pkg::DropW-1:0] drop_q;
  ksa_pkg::tok_t inj_q;
  ksa_pkg::cell_ctrl_t ctrl;
  ksa_pkg::tok_t tok [N+1];
  logic valid_w [N+1];
  ksa_pkg::entry_t ent_w [N+1];
  logic div_start, div_busy, div_done;
  logic signed [31:0] div_q;
  logic out_valid_q;
  logic [15:0] osrc_q, omet_q, odrop_q;
  logic signed [31:0] oavg_q, omin_q, omax_q;
  logic olast_q;
  logic rest_valid;

  assign tok[0] = inj_q;
  assign valid_w[N] = 1'b0;
  assign ent_w[N] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    ksa_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl),
      .tok_i(tok[g]), .tok_o(tok[g+1]),
      .nxt_valid_i(valid_w[g+1]), .nxt_entry_i(ent_w[g+1]),
      .valid_o(valid_w[g]), .entry_o(ent_w[g])
    );
  end

  always_comb begin
    rest_valid = 1'b0;
    for (int i = 1; i < N; i++) rest_valid = rest_valid | valid_w[i];
  end

  assign div_start = (state_q == S_FSTART) && valid_w[0];

  ksa_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(ent_w[0].sum), .den_i(ent_w[0].count),
    .busy_o(div_busy), .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    ctrl.clear = (state_q == S_FSTART) && !valid_w[0];
    ctrl.shift = (state_q == S_FSHIFT);
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      drop_q <= '0;
      inj_q <= '0;
      out_valid_q <= 1'b0;
      osrc_q <= '0;
      omet_q <= '0;
      oavg_q <= '0;
      omin_q <= '0;
      omax_q <= '0;
      odrop_q <= '0;
      olast_q <= 1'b0;
    end else begin
      if (state_q != S_IDLE) inj_q.active <= 1'b0;
      if (out_valid_q && !out_stall_i && state_q != S_FOUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (req_type_i == ksa_pkg::ReqFlush) begin
              state_q <= S_FSTART;
            end else begin
              inj_q.active <= 1'b1;
              inj_q.done <= 1'b0;
              inj_q.key <= {source_id_i, metric_type_i};
              inj_q.value <= sample_value_i;
              cnt_q <= '0;
              state_q <= S_ADD;
            end
          end
        end
        S_ADD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(N)) begin
            state_q <= S_IDLE;
            if (!tok[N].done && drop_q != ksa_pkg::DropMax) drop_q <= drop_q + 1'b1;
          end
        end
        S_FSTART: begin
          if (valid_w[0]) begin
            state_q <= S_FDIV;
          end else begin
            drop_q <= '0;
            state_q <= S_IDLE;
          end
        end
        S_FDIV: begin
          if (div_done) state_q <= S_FOUT;
        end
        S_FOUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            osrc_q <= ent_w[0].key[31:16];
            omet_q <= ent_w[0].key[15:0];
            oavg_q <= div_q;
            omin_q <= ent_w[0].min;
            omax_q <= ent_w[0].max;
            odrop_q <= drop_q;
            olast_q <= !rest_valid;
            state_q <= S_FSHIFT;
          end
        end
        S_FSHIFT: begin
          state_q <= S_FSTART;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_source_id_o = osrc_q;
  assign out_metric_type_o = omet_q;
  assign average_o = oavg_q;
  assign minimum_o = omin_q;
  assign maximum_o = omax_q;
  assign dropped_keys_o = odrop_q;
  assign last_o = olast_q;

endmodule

// ===== tb/keyed_stats_accumulator_test.sv =====
`timescale 1ns / 1ps

module keyed_stats_accumulator_test;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned Slots = ksa_pkg::Entries;

  typedef struct packed {
    logic        req;
    logic [15:0] src;
    logic [15:0] metric;
    logic signed [31:0] sample;
  } req_item_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] metric;
    logic signed [31:0] avg;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [15:0] drops;
    logic        last;
  } record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = ksa_pkg::ReqAdd;
  logic [15:0] source_id_i = '0;
  logic [15:0] metric_type_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] out_source_id_o, out_metric_type_o, dropped_keys_o;
  logic signed [31:0] average_o, minimum_o, maximum_o;
  logic last_o;

  keyed_stats_accumulator dut (.*);

  always #5 clk_i = ~clk_i;

  req_item_t pending_q[$];
  record_t   record_q[$];

  logic        tbl_valid[Slots];
  logic [31:0] tbl_key[Slots];
  logic signed [63:0] tbl_sum[Slots];
  logic [31:0] tbl_count[Slots];
  logic signed [31:0] tbl_lo[Slots];
  logic signed [31:0] tbl_hi[Slots];
  logic [15:0] drop_count;

  int errors = 0;
  int adds_done = 0;
  int flushes_done = 0;
  int records_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  task automatic predict(input req_item_t it);
    logic [31:0] key;
    int free_idx;
    int last_idx;
    record_t rec;
    key = {it.src, it.metric};
    free_idx = -1;
    if (it.req == ksa_pkg::ReqFlush) begin
      last_idx = -1;
      for (int i = 0; i < Slots; i++) if (tbl_valid[i]) last_idx = i;
      for (int i = 0; i < Slots; i++) begin
        if (!tbl_valid[i]) continue;
        rec.src = tbl_key[i][31:16];
        rec.metric = tbl_key[i][15:0];
        rec.avg = 32'(tbl_sum[i] / $signed({32'd0, tbl_count[i]}));
        rec.lo = tbl_lo[i];
        rec.hi = tbl_hi[i];
        rec.drops = drop_count;
        rec.last = (i == last_idx);
        record_q.push_back(rec);
        tbl_valid[i] = 1'b0;
      end
      drop_count = '0;
      return;
    end
    for (int i = 0; i < Slots; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) begin
        if (tbl_count[i] != ksa_pkg::CountMax) begin
          tbl_sum[i] += 64'(it.sample);
          tbl_count[i]++;
        end
        if (it.sample < tbl_lo[i]) tbl_lo[i] = it.sample;
        if (it.sample > tbl_hi[i]) tbl_hi[i] = it.sample;
        return;
      end
      if (!tbl_valid[i] && free_idx < 0) free_idx = i;
    end
    if (free_idx < 0) begin
      if (drop_count != ksa_pkg::DropMax) drop_count++;
      return;
    end
    tbl_valid[free_idx] = 1'b1;
    tbl_key[free_idx] = key;
    tbl_sum[free_idx] = 64'(it.sample);
    tbl_count[free_idx] = 1;
    tbl_lo[free_idx] = it.sample;
    tbl_hi[free_idx] = it.sample;
  endtask

  function automatic req_item_t add_item(input logic [15:0] s, input logic [15:0] m,
                                         input logic [31:0] v);
    req_item_t it;
    it.req = ksa_pkg::ReqAdd;
    it.src = s;
    it.metric = m;
    it.sample = v;
    return it;
  endfunction

  function automatic req_item_t flush_item();
    req_item_t it;
    it = add_item(16'($urandom), 16'($urandom), $urandom);
    it.req = ksa_pkg::ReqFlush;
    return it;
  endfunction

  initial begin
    int nkeys;
    logic [15:0] ks[8];
    logic [15:0] km[8];
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    drop_count = '0;
    pending_q.push_back(flush_item());
    pending_q.push_back(add_item(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF));
    pending_q.push_back(add_item(16'hFFFF, 16'hFFFF, 32'h8000_0000));
    pending_q.push_back(add_item(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    pending_q.push_back(add_item(16'h0000, 16'h0000, 32'h8000_0000));
    pending_q.push_back(add_item(16'h0000, 16'h0000, 32'h8000_0000));
    pending_q.push_back(add_item(16'h0000, 16'hFFFF, 32'hFFFF_FFFD));
    pending_q.push_back(add_item(16'h0000, 16'hFFFF, 32'h0000_0001));
    pending_q.push_back(flush_item());
    for (int i = 0; i < Slots + 3; i++)
      pending_q.push_back(add_item(16'(i), 16'hA5A5, $urandom));
    pending_q.push_back(add_item(16'h0003, 16'hA5A5, 32'h8000_0000));
    pending_q.push_back(flush_item());
    while (pending_q.size() < 125) begin
      nkeys = $urandom_range(1, 8);
      for (int k = 0; k < nkeys; k++) begin
        ks[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        km[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      end
      repeat ($urandom_range(2, 12)) begin
        int k;
        logic [31:0] v;
        k = $urandom_range(0, nkeys - 1);
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'($signed($urandom_range(0, 200)) - 100);
          default: v = $urandom;
        endcase
        pending_q.push_back(add_item(ks[k], km[k], v));
      end
      pending_q.push_back(flush_item());
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict({req_type_i, source_id_i, metric_type_i, sample_value_i});
      if (req_type_i == ksa_pkg::ReqFlush) flushes_done++;
      else adds_done++;
    end
    if (in_valid_i && in_stall_o) begin
    end else if (pending_q.size() != 0 && rst_ni && (burst_left > 0 || gap_left == 0)) begin
      req_item_t it;
      it = pending_q.pop_front();
      in_valid_i <= 1'b1;
      req_type_i <= it.req;
      source_id_i <= it.src;
      metric_type_i <= it.metric;
      sample_value_i <= it.sample;
      if (burst_left > 0) burst_left <= burst_left - 1;
      else begin
        burst_left <= $urandom_range(0, 10);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid_i <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
      if (pending_q.size() == 0 && rst_ni) stim_done <= 1'b1;
    end
  end

  int stall_phase = 0;
  int hold_cycles = 0;

  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 23;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_off && flushes_done == 3) begin
      hold_off <= 1'b1;
      hold_cycles <= 3000;
      out_stall_i <= 1'b1;
    end else if (stall_phase < 8) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    record_t got, want;
    if (out_valid_o && !out_stall_i) begin
      got = {out_source_id_o, out_metric_type_o, average_o, minimum_o, maximum_o,
             dropped_keys_o, last_o};
      records_seen++;
      if (record_q.size() == 0) begin
        $display("%0t: unexpected record %p", $time, got);
        errors++;
      end else begin
        want = record_q.pop_front();
        if (got.src !== want.src)
          $display("%0t: source exp %h got %h", $time, want.src, got.src);
        if (got.metric !== want.metric)
          $display("%0t: metric exp %h got %h", $time, want.metric, got.metric);
        if (got.avg !== want.avg)
          $display("%0t: average exp %0d got %0d", $time, want.avg, got.avg);
        if (got.lo !== want.lo)
          $display("%0t: minimum exp %0d got %0d", $time, want.lo, got.lo);
        if (got.hi !== want.hi)
          $display("%0t: maximum exp %0d got %0d", $time, want.hi, got.hi);
        if (got.drops !== want.drops)
          $display("%0t: dropped exp %0d got %0d", $time, want.drops, got.drops);
        if (got.last !== want.last)
          $display("%0t: last exp %b got %b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: %0d records still expected", record_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && !in_valid_i && record_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d adds and %0d flushes, %0d records checked", adds_done,
             flushes_done, records_seen);
    if (errors == 0 && record_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== keyed_stats_accumulator.f =====
rtl/core/ksa_pkg.sv
rtl/core/ksa_cell.sv
rtl/core/ksa_div.sv
rtl/core/keyed_stats_accumulator.sv
tb/keyed_stats_accumulator_test.sv
